// ===== sv/agps_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive gain PD steering package
// Shared types and constants for the steering controller, its datapath and its
// register file.
// ----------------------------------------------------------------------------
package agps_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [7:0]  MIN_VALID_ROWS   = 8'd20;
    localparam logic [5:0]  LOST_FRAME_LIMIT = 6'd25;
    localparam logic [7:0]  GAP_CAP          = 8'd20;
    localparam logic [11:0] SPREAD_THRESHOLD = 12'd120;
    localparam logic [15:0] STRAIGHT_KP      = 16'd1536;
    localparam logic [15:0] STRAIGHT_KD      = 16'd2304;
    localparam logic [11:0] DIV5_RECIP       = 12'd3277;
    localparam int unsigned DIV5_SHIFT       = 14;
    localparam logic signed [9:0] SETTLE_BOUND = 10'sd5;

    localparam logic [15:0] RST_MIN_GAIN     = 16'd1997;
    localparam logic [15:0] RST_MAX_GAIN     = 16'd2253;
    localparam logic [7:0]  RST_BOOST_SCALE  = 8'd102;
    localparam logic [15:0] RST_DERIV_GAIN   = 16'd2304;
    localparam logic [15:0] RST_SERVO_CENTER = 16'd1500;
    localparam logic [15:0] RST_SERVO_UPPER  = 16'd1700;
    localparam logic [15:0] RST_SERVO_LOWER  = 16'd1300;

    typedef enum logic [2:0] {
        REG_MIN_GAIN     = 3'd0,
        REG_MAX_GAIN     = 3'd1,
        REG_BOOST_SCALE  = 3'd2,
        REG_DERIV_GAIN   = 3'd3,
        REG_SERVO_CENTER = 3'd4,
        REG_SERVO_UPPER  = 3'd5,
        REG_SERVO_LOWER  = 3'd6,
        REG_STOP_ENABLE  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [9:0] frame_error;
        logic [7:0]        lookahead_row;
        logic [7:0]        left_end_row;
        logic [7:0]        right_end_row;
        logic [11:0]       spread;
        logic              turn_side;
        logic              block_present;
        logic              road_straight;
        logic [7:0]        left_valid_rows;
        logic [7:0]        right_valid_rows;
    } t_in_item;

    typedef struct packed {
        logic [15:0] servo_duty;
        logic        duty_updated;
        logic        stop_request;
        logic        straight_settled;
    } t_out_item;

    typedef struct packed {
        logic [15:0] min_gain;
        logic [15:0] max_gain;
        logic [7:0]  boost_scale;
        logic [15:0] deriv_gain;
        logic [15:0] servo_center;
        logic [15:0] servo_upper;
        logic [15:0] servo_lower;
        logic        stop_enable;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic boost;
        logic div;
        logic kp_mul;
        logic kp_sel;
        logic mul_p;
        logic mul_d;
        logic acc;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic lost;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/agps_cfg.sv =====
// ----------------------------------------------------------------------------
// Adaptive gain PD steering register file
// APB-style configuration registers with reset values and read-back.
// ----------------------------------------------------------------------------
module agps_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [agps_pkg::ADDR_W-1:0]   paddr,
    input  logic [agps_pkg::DATA_W-1:0]   pwdata,
    output logic [agps_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output agps_pkg::t_cfg                o_cfg
);

    agps_pkg::t_cfg     r_cfg;
    agps_pkg::t_reg_idx idx;
    logic               wr_en;

    assign idx    = agps_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_gain     <= agps_pkg::RST_MIN_GAIN;
            r_cfg.max_gain     <= agps_pkg::RST_MAX_GAIN;
            r_cfg.boost_scale  <= agps_pkg::RST_BOOST_SCALE;
            r_cfg.deriv_gain   <= agps_pkg::RST_DERIV_GAIN;
            r_cfg.servo_center <= agps_pkg::RST_SERVO_CENTER;
            r_cfg.servo_upper  <= agps_pkg::RST_SERVO_UPPER;
            r_cfg.servo_lower  <= agps_pkg::RST_SERVO_LOWER;
            r_cfg.stop_enable  <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                agps_pkg::REG_MIN_GAIN:     r_cfg.min_gain     <= pwdata[15:0];
                agps_pkg::REG_MAX_GAIN:     r_cfg.max_gain     <= pwdata[15:0];
                agps_pkg::REG_BOOST_SCALE:  r_cfg.boost_scale  <= pwdata[7:0];
                agps_pkg::REG_DERIV_GAIN:   r_cfg.deriv_gain   <= pwdata[15:0];
                agps_pkg::REG_SERVO_CENTER: r_cfg.servo_center <= pwdata[15:0];
                agps_pkg::REG_SERVO_UPPER:  r_cfg.servo_upper  <= pwdata[15:0];
                agps_pkg::REG_SERVO_LOWER:  r_cfg.servo_lower  <= pwdata[15:0];
                agps_pkg::REG_STOP_ENABLE:  r_cfg.stop_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            agps_pkg::REG_MIN_GAIN:     prdata = {16'd0, r_cfg.min_gain};
            agps_pkg::REG_MAX_GAIN:     prdata = {16'd0, r_cfg.max_gain};
            agps_pkg::REG_BOOST_SCALE:  prdata = {24'd0, r_cfg.boost_scale};
            agps_pkg::REG_DERIV_GAIN:   prdata = {16'd0, r_cfg.deriv_gain};
            agps_pkg::REG_SERVO_CENTER: prdata = {16'd0, r_cfg.servo_center};
            agps_pkg::REG_SERVO_UPPER:  prdata = {16'd0, r_cfg.servo_upper};
            agps_pkg::REG_SERVO_LOWER:  prdata = {16'd0, r_cfg.servo_lower};
            agps_pkg::REG_STOP_ENABLE:  prdata = {31'd0, r_cfg.stop_enable};
            default:                    prdata = '0;
        endcase
    end

endmodule

// ===== sv/agps_ctrl.sv =====
// ----------------------------------------------------------------------------
// Adaptive gain PD steering controller
// Sequences the datapath through the gain, multiply and clamp steps of a word.
// ----------------------------------------------------------------------------
module agps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  agps_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output agps_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BOOST,
        ST_DIV,
        ST_KP_MUL,
        ST_KP_SEL,
        ST_MUL_P,
        ST_MUL_D,
        ST_ACC,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_BOOST;
            ST_BOOST:  n_state = i_sts.lost ? ST_FIN : ST_DIV;
            ST_DIV:    n_state = ST_KP_MUL;
            ST_KP_MUL: n_state = ST_KP_SEL;
            ST_KP_SEL: n_state = ST_MUL_P;
            ST_MUL_P:  n_state = ST_MUL_D;
            ST_MUL_D:  n_state = ST_ACC;
            ST_ACC:    n_state = ST_FIN;
            ST_FIN:    if (i_sts.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_cmd.load    = (r_state == ST_IDLE) & i_in_valid;
    assign o_cmd.boost   = (r_state == ST_BOOST);
    assign o_cmd.div     = (r_state == ST_DIV);
    assign o_cmd.kp_mul  = (r_state == ST_KP_MUL);
    assign o_cmd.kp_sel  = (r_state == ST_KP_SEL);
    assign o_cmd.mul_p   = (r_state == ST_MUL_P);
    assign o_cmd.mul_d   = (r_state == ST_MUL_D);
    assign o_cmd.acc     = (r_state == ST_ACC);
    assign o_cmd.fin     = (r_state == ST_FIN) & i_sts.out_free;

endmodule

// ===== sv/agps_dp.sv =====
// ----------------------------------------------------------------------------
// Adaptive gain PD steering datapath
// Gain boost, PD sum, duty clamp, frame state and the output register.
// ----------------------------------------------------------------------------
module agps_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  agps_pkg::t_cmd      i_cmd,
    input  agps_pkg::t_in_item  i_in_data,
    input  agps_pkg::t_cfg      i_cfg,
    input  logic                i_out_ready,
    output agps_pkg::t_sts      o_sts,
    output logic                o_out_valid,
    output agps_pkg::t_out_item o_out_data
);

    agps_pkg::t_in_item  r_item;
    agps_pkg::t_out_item r_out;
    logic                r_out_valid;
    logic [12:0]         r_prod;
    logic [7:0]          r_boost;
    logic [23:0]         r_kp_prod;
    logic [15:0]         r_kp;
    logic [15:0]         r_kd;
    logic signed [26:0]  r_pterm;
    logic signed [27:0]  r_dterm;
    logic signed [29:0]  r_acc;
    logic signed [9:0]   r_prev;
    logic [4:0]          r_lost_cnt;
    logic                r_stop;
    logic                r_settled;
    logic [15:0]         r_held;

    logic [7:0]          end_row;
    logic [7:0]          gap;
    logic [4:0]          gap_cap;
    logic [22:0]         div_prod;
    logic [16:0]         kp_sum;
    logic [16:0]         kp_blk;
    logic [15:0]         kp_lim;
    logic signed [9:0]   err;
    logic signed [10:0]  diff;
    logic signed [26:0]  n_pterm;
    logic signed [27:0]  n_dterm;
    logic signed [29:0]  n_acc;
    logic signed [21:0]  quo;
    logic signed [21:0]  duty_t;
    logic signed [21:0]  upper_s;
    logic signed [21:0]  lower_s;
    logic [15:0]         duty_clamped;
    logic                lost;
    logic                settle_now;
    logic [5:0]          cnt_inc;
    logic [15:0]         n_held;
    logic [4:0]          n_lost_cnt;
    logic                n_stop;
    logic                n_settled;

    assign err  = r_item.frame_error;
    assign lost = (r_item.left_valid_rows <= agps_pkg::MIN_VALID_ROWS)
                && (r_item.right_valid_rows <= agps_pkg::MIN_VALID_ROWS);

    always_comb begin
        end_row = r_item.turn_side ? r_item.right_end_row : r_item.left_end_row;
        if (end_row < r_item.lookahead_row) begin
            gap = r_item.lookahead_row - end_row;
        end else if (r_item.spread > agps_pkg::SPREAD_THRESHOLD) begin
            gap = end_row - r_item.lookahead_row;
        end else begin
            gap = 8'd0;
        end
        gap_cap = (gap > agps_pkg::GAP_CAP) ? agps_pkg::GAP_CAP[4:0] : gap[4:0];
    end

    assign div_prod = 23'(r_prod[12:2]) * 23'(agps_pkg::DIV5_RECIP);

    always_comb begin
        kp_sum = {1'b0, i_cfg.min_gain} + {1'b0, r_kp_prod[23:8]};
        kp_blk = r_item.block_present ? {1'b0, i_cfg.max_gain} : kp_sum;
        kp_lim = (kp_blk > {1'b0, i_cfg.max_gain}) ? i_cfg.max_gain : kp_blk[15:0];
    end

    assign diff    = {err[9], err} - {r_prev[9], r_prev};
    assign n_pterm = $signed({1'b0, r_kp}) * err;
    assign n_dterm = $signed({1'b0, r_kd}) * diff;
    assign n_acc   = $signed({6'd0, i_cfg.servo_center, 8'd0})
                   - 30'(r_pterm) - 30'(r_dterm);

    always_comb begin
        quo     = r_acc[29:8];
        duty_t  = (r_acc[29] && (r_acc[7:0] != 8'd0)) ? quo + 22'sd1 : quo;
        upper_s = $signed({6'd0, i_cfg.servo_upper});
        lower_s = $signed({6'd0, i_cfg.servo_lower});
        if (duty_t > upper_s) begin
            duty_clamped = i_cfg.servo_upper;
        end else if (duty_t < lower_s) begin
            duty_clamped = i_cfg.servo_lower;
        end else begin
            duty_clamped = duty_t[15:0];
        end
    end

    assign settle_now = (err > -agps_pkg::SETTLE_BOUND) && (err < agps_pkg::SETTLE_BOUND);
    assign cnt_inc    = {1'b0, r_lost_cnt} + 6'd1;

    always_comb begin
        n_held     = r_held;
        n_lost_cnt = 5'd0;
        n_stop     = r_stop;
        n_settled  = r_settled;
        if (lost) begin
            if (cnt_inc > agps_pkg::LOST_FRAME_LIMIT) begin
                n_stop = r_stop | i_cfg.stop_enable;
            end else begin
                n_lost_cnt = cnt_inc[4:0];
            end
        end else begin
            n_held = duty_clamped;
            if (r_item.road_straight && settle_now) begin
                n_settled = 1'b1;
            end else if (!r_item.road_straight) begin
                n_settled = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.boost) begin
            r_prod <= 13'(gap_cap) * 13'(i_cfg.boost_scale);
        end
        if (i_cmd.div) begin
            r_boost <= div_prod[agps_pkg::DIV5_SHIFT+7:agps_pkg::DIV5_SHIFT];
        end
        if (i_cmd.kp_mul) begin
            r_kp_prod <= 24'(i_cfg.min_gain) * 24'(r_boost);
        end
        if (i_cmd.kp_sel) begin
            r_kp <= r_item.road_straight ? agps_pkg::STRAIGHT_KP : kp_lim;
            r_kd <= r_item.road_straight ? agps_pkg::STRAIGHT_KD : i_cfg.deriv_gain;
        end
        if (i_cmd.mul_p) begin
            r_pterm <= n_pterm;
        end
        if (i_cmd.mul_d) begin
            r_dterm <= n_dterm;
        end
        if (i_cmd.acc) begin
            r_acc <= n_acc;
        end
        if (i_cmd.fin) begin
            r_out.servo_duty       <= n_held;
            r_out.duty_updated     <= !lost;
            r_out.stop_request     <= n_stop;
            r_out.straight_settled <= n_settled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_lost_cnt  <= '0;
            r_stop      <= 1'b0;
            r_settled   <= 1'b0;
            r_held      <= agps_pkg::RST_SERVO_CENTER;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.fin) begin
                r_held      <= n_held;
                r_lost_cnt  <= n_lost_cnt;
                r_stop      <= n_stop;
                r_settled   <= n_settled;
                r_out_valid <= 1'b1;
                if (!lost) begin
                    r_prev <= err;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.lost     = lost;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

// ===== sv/adaptive_gain_pd_steering.sv =====
// One word in, one word out: each accepted frame word produces one result word
// through an accept state, seven sequenced steps (the gap boost, the
// reciprocal division by twenty, the gain multiply and select, the two PD
// multiplies and the sum) and a final step that truncates, clamps and registers
// the duty once the output register is free; a frame with lost lines goes from
// the gap boost straight to the final step. The block works on one frame at a
// time, and the finished word waits in an output register so that the next
// frame is taken while it is unread. Configuration writes are taken in any
// state and must only be made while the block is idle.
// ----------------------------------------------------------------------------
// Adaptive gain PD steering top level
// PD servo steering with a proportional gain boosted by the lookahead gap.
// ----------------------------------------------------------------------------
module adaptive_gain_pd_steering (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  agps_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output agps_pkg::t_out_item         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [agps_pkg::ADDR_W-1:0] paddr,
    input  logic [agps_pkg::DATA_W-1:0] pwdata,
    output logic [agps_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    agps_pkg::t_cfg cfg;
    agps_pkg::t_cmd cmd;
    agps_pkg::t_sts sts;

    agps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    agps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    agps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg       (cfg),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready
    ) else $error("Block accepted a word while another was in progress.");

    a_stop_sticky: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.stop_request)
            |=> (!o_out_valid || o_out_data.stop_request)
    ) else $error("Latched stop request was dropped.");

    a_duty_in_limits: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.duty_updated
            && (cfg.servo_lower <= cfg.servo_upper))
            |-> ((o_out_data.servo_duty >= cfg.servo_lower)
                && (o_out_data.servo_duty <= cfg.servo_upper))
    ) else $error("Updated servo duty lies outside the configured limits.");

endmodule
